>>> rtl/afat_pkg.sv
// shared constants, operation and register codes, command and status types
package afat_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = 7;
  localparam int TIME_BITS  = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int OP_W       = 2;
  localparam int DIV_CNT_W  = $clog2(TIME_BITS + 1);
  localparam int SEL_W      = 3;

  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_AT   = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTION_TIME = 2'd2;

  // source of the frame index on a result
  localparam logic [SEL_W-1:0] SEL_LAST  = 3'd0;
  localparam logic [SEL_W-1:0] SEL_ZERO  = 3'd1;
  localparam logic [SEL_W-1:0] SEL_SCAN  = 3'd2;
  localparam logic [SEL_W-1:0] SEL_CLAMP = 3'd3;
  localparam logic [SEL_W-1:0] SEL_REM   = 3'd4;

  typedef struct packed {
    logic             load_we;
    logic             capture_at;
    logic             capture_next;
    logic             div_start_time;
    logic             div_start_next;
    logic             use_rem;
    logic             hint_rd;
    logic             scan_back;
    logic             scan_fwd;
    logic             scan_step;
    logic             emit;
    logic [SEL_W-1:0] sel;
  } afat_cmd_t;

  typedef struct packed {
    logic loop_mode;
    logic t_ge_action;
    logic action_zero;
    logic div_busy;
    logic hint_gt;
    logic hint_zero;
    logic scan_end;
  } afat_stat_t;

endpackage

>>> rtl/afat_ram.sv
// generic simple dual-port ram with registered read
module afat_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/afat_dp.sv
// datapath: config registers, start time table, modulo unit, frame search
module afat_dp import afat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  afat_cmd_t            cmd,
  output afat_stat_t           stat,
  input  logic [TIME_BITS-1:0] query_time,
  input  logic [IDX_W-1:0]     hint_frame,
  input  logic [IDX_W-1:0]     current_frame,
  input  logic [IDX_W-1:0]     entry_index,
  input  logic [TIME_BITS-1:0] entry_start,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output logic [IDX_W-1:0]     frame,
  output logic                 bad_hint
);

  logic                 play_mode;
  logic [CNT_W-1:0]     frame_count;
  logic [TIME_BITS-1:0] action_time;
  logic [CNT_W-1:0]     n;
  logic [CNT_W-1:0]     n_m1;

  logic [TIME_BITS-1:0] t_r;
  logic [IDX_W-1:0]     hint_r;
  logic [IDX_W-1:0]     cur_r;
  logic                 bad_r;
  logic                 hint_bad;
  logic                 cur_bad;
  logic [CNT_W-1:0]     cur_inc;

  logic [TIME_BITS-1:0] div_num;
  logic [TIME_BITS-1:0] div_den;
  logic [TIME_BITS-1:0] div_rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [TIME_BITS:0]   div_trial;
  logic [TIME_BITS:0]   div_diff;
  logic                 div_fit;

  logic [CNT_W-1:0]     scan_addr;
  logic [CNT_W-1:0]     scan_lim;
  logic [CNT_W-1:0]     scan_lim_m1;
  logic [IDX_W-1:0]     scan_prev;
  logic                 scan_pend;
  logic                 scan_more;
  logic                 scan_hit;
  logic [IDX_W-1:0]     scan_frame;

  logic [IDX_W-1:0]     rd_addr;
  logic [TIME_BITS-1:0] rd_data;
  logic [IDX_W-1:0]     sel_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      play_mode   <= 1'b0;
      frame_count <= CNT_W'(1);
      action_time <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLAY_MODE:   play_mode   <= cfg_data[0];
        REG_FRAME_COUNT: frame_count <= cfg_data[CNT_W-1:0];
        REG_ACTION_TIME: action_time <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // frames in use, count held to 1..MAX_FRAMES
  always_comb begin
    if (frame_count == '0) begin
      n = CNT_W'(1);
    end else if (frame_count > CNT_W'(MAX_FRAMES)) begin
      n = CNT_W'(MAX_FRAMES);
    end else begin
      n = frame_count;
    end
  end

  assign n_m1     = n - CNT_W'(1);
  assign hint_bad = CNT_W'(hint_frame) >= n;
  assign cur_bad  = CNT_W'(current_frame) >= n;
  assign cur_inc  = CNT_W'(cur_r) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.capture_at) begin
      t_r    <= query_time;
      bad_r  <= hint_bad;
      hint_r <= hint_bad ? '0 : hint_frame;
    end else if (cmd.capture_next) begin
      cur_r <= current_frame;
      bad_r <= cur_bad;
    end else if (cmd.use_rem) begin
      t_r <= div_rem;
    end
  end

  // restoring modulo, one dividend bit per cycle
  assign div_trial = {div_rem, div_num[TIME_BITS-1]};
  assign div_diff  = div_trial - {1'b0, div_den};
  assign div_fit   = div_trial >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start_time) begin
      div_num <= t_r;
      div_den <= action_time;
      div_rem <= '0;
      div_cnt <= DIV_CNT_W'(TIME_BITS);
    end else if (cmd.div_start_next) begin
      div_num <= TIME_BITS'(cur_inc);
      div_den <= TIME_BITS'(n);
      div_rem <= '0;
      div_cnt <= DIV_CNT_W'(TIME_BITS);
    end else if (div_cnt != '0) begin
      div_rem <= div_fit ? div_diff[TIME_BITS-1:0] : div_trial[TIME_BITS-1:0];
      div_num <= {div_num[TIME_BITS-2:0], 1'b0};
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  // streaming scan: one read issued per cycle, compare on the data of the last one
  assign scan_more   = scan_addr < scan_lim;
  assign scan_hit    = scan_pend && (rd_data > t_r);
  assign scan_lim_m1 = scan_lim - CNT_W'(1);
  assign scan_frame  = scan_hit ? (scan_prev - IDX_W'(1)) : scan_lim_m1[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pend <= 1'b0;
    end else if (cmd.scan_back) begin
      scan_addr <= CNT_W'(1);
      scan_lim  <= CNT_W'(hint_r);
      scan_pend <= 1'b0;
    end else if (cmd.scan_fwd) begin
      scan_addr <= CNT_W'(hint_r) + CNT_W'(1);
      scan_lim  <= n;
      scan_pend <= 1'b0;
    end else if (cmd.scan_step) begin
      if (!scan_hit && scan_more) begin
        scan_prev <= scan_addr[IDX_W-1:0];
        scan_addr <= scan_addr + CNT_W'(1);
        scan_pend <= 1'b1;
      end else begin
        scan_pend <= 1'b0;
      end
    end
  end

  assign rd_addr = cmd.hint_rd ? hint_r : scan_addr[IDX_W-1:0];

  afat_ram #(
    .WIDTH(TIME_BITS),
    .DEPTH(MAX_FRAMES)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.load_we),
    .waddr (entry_index),
    .wdata (entry_start),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    unique case (cmd.sel)
      SEL_LAST:  sel_frame = n_m1[IDX_W-1:0];
      SEL_ZERO:  sel_frame = '0;
      SEL_SCAN:  sel_frame = scan_frame;
      SEL_CLAMP: sel_frame = (CNT_W'(cur_r) < n_m1) ? cur_inc[IDX_W-1:0] : n_m1[IDX_W-1:0];
      SEL_REM:   sel_frame = div_rem[IDX_W-1:0];
      default:   sel_frame = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      frame    <= sel_frame;
      bad_hint <= bad_r;
    end
  end

  assign stat.loop_mode   = play_mode;
  assign stat.t_ge_action = t_r >= action_time;
  assign stat.action_zero = action_time == '0;
  assign stat.div_busy    = div_cnt != '0;
  assign stat.hint_gt     = rd_data > t_r;
  assign stat.hint_zero   = hint_r == '0;
  assign stat.scan_end    = scan_hit || !scan_more;

endmodule

>>> rtl/afat_ctrl.sv
// controller state machine sequencing loads, lookups and frame advance
module afat_ctrl import afat_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [OP_W-1:0] operation,
  output logic            busy,
  output afat_cmd_t       cmd,
  input  afat_stat_t      stat
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_AT_CHK  = 3'd1;
  localparam logic [2:0] S_NXT_CHK = 3'd2;
  localparam logic [2:0] S_MOD     = 3'd3;
  localparam logic [2:0] S_HISSUE  = 3'd4;
  localparam logic [2:0] S_HCMP    = 3'd5;
  localparam logic [2:0] S_SCAN    = 3'd6;

  logic [2:0]      state;
  logic [2:0]      state_next;
  logic [OP_W-1:0] op_r;

  assign busy = state != S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r <= operation;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (operation)
            OP_LOAD: cmd.load_we = 1'b1;
            OP_AT: begin
              cmd.capture_at = 1'b1;
              state_next     = S_AT_CHK;
            end
            OP_NEXT: begin
              cmd.capture_next = 1'b1;
              state_next       = S_NXT_CHK;
            end
            default: ;
          endcase
        end
      end
      S_AT_CHK: begin
        if (!stat.loop_mode && stat.t_ge_action) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_LAST;
          state_next = S_IDLE;
        end else if (stat.loop_mode && !stat.action_zero) begin
          cmd.div_start_time = 1'b1;
          state_next         = S_MOD;
        end else begin
          cmd.hint_rd = 1'b1;
          state_next  = S_HCMP;
        end
      end
      S_NXT_CHK: begin
        if (!stat.loop_mode) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_CLAMP;
          state_next = S_IDLE;
        end else begin
          cmd.div_start_next = 1'b1;
          state_next         = S_MOD;
        end
      end
      S_MOD: begin
        if (!stat.div_busy) begin
          if (op_r == OP_NEXT) begin
            cmd.emit   = 1'b1;
            cmd.sel    = SEL_REM;
            state_next = S_IDLE;
          end else begin
            cmd.use_rem = 1'b1;
            state_next  = S_HISSUE;
          end
        end
      end
      S_HISSUE: begin
        cmd.hint_rd = 1'b1;
        state_next  = S_HCMP;
      end
      S_HCMP: begin
        // hint start lies after the time: frame 0 if the hint is frame 0, else search again from the front
        if (stat.hint_gt) begin
          if (stat.hint_zero) begin
            cmd.emit   = 1'b1;
            cmd.sel    = SEL_ZERO;
            state_next = S_IDLE;
          end else begin
            cmd.scan_back = 1'b1;
            state_next    = S_SCAN;
          end
        end else begin
          cmd.scan_fwd = 1'b1;
          state_next   = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_end) begin
          cmd.emit   = 1'b1;
          cmd.sel    = SEL_SCAN;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/animation_frame_at_time_top.sv
// top level: frame lookup by time over a table of frame start times
//
// Items are taken with start while busy is low; operation selects a table
// load, a frame-at-time query or a next-frame query. Configuration writes go
// through cfg_we / cfg_index / cfg_data only while the block is idle, which
// the user must see to; the block does not enforce it. A load is written in
// the transfer cycle itself and never raises busy. Queries raise busy; their
// result shows on frame / bad_hint for exactly one cycle with done high, and
// the receiver must take it then. Query paths to the result:
//   next frame, one-shot: a direct result; next frame, loop: the result of
//   the 32-step bit-serial modulo unit
//   frame at time, one-shot past the end: a direct result
//   frame at time otherwise: a hint read, then a scan of k entries (at most
//   the frame count less one), one table read per cycle on the ram read
//   port; no scan when frame 0 is the hint and starts after the time;
//   loop mode with nonzero duration runs the modulo first.
// One query is in flight at a time; the next transfer is taken in the cycle
// done goes high. Reset returns the controller to idle and the registers to
// one-shot, one frame, zero duration; the table is not cleared and holds
// undefined data until loaded.
module animation_frame_at_time_top import afat_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [OP_W-1:0]      operation,
  input  logic [TIME_BITS-1:0] query_time,
  input  logic [IDX_W-1:0]     hint_frame,
  input  logic [IDX_W-1:0]     current_frame,
  input  logic [IDX_W-1:0]     entry_index,
  input  logic [TIME_BITS-1:0] entry_start,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output logic                 done,
  output logic [IDX_W-1:0]     frame,
  output logic                 bad_hint
);

  afat_cmd_t  cmd;
  afat_stat_t stat;

  afat_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .busy      (busy),
    .cmd       (cmd),
    .stat      (stat)
  );

  afat_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .query_time    (query_time),
    .hint_frame    (hint_frame),
    .current_frame (current_frame),
    .entry_index   (entry_index),
    .entry_start   (entry_start),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .done          (done),
    .frame         (frame),
    .bad_hint      (bad_hint)
  );

endmodule

>>> rtl/afat_checker.sv
// port-level checks on the frame lookup block, bound to its top level
module afat_checker import afat_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic [OP_W-1:0]      operation,
  input logic [TIME_BITS-1:0] query_time,
  input logic [IDX_W-1:0]     hint_frame,
  input logic [IDX_W-1:0]     current_frame,
  input logic [IDX_W-1:0]     entry_index,
  input logic [TIME_BITS-1:0] entry_start,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [CFG_W-1:0]     cfg_data,
  input logic                 done,
  input logic [IDX_W-1:0]     frame,
  input logic                 bad_hint
);

  // loads finish in their transfer cycle
  a_load_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == OP_LOAD) |=> !busy)
    else $error("busy raised by a table load");

  a_query_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (operation == OP_AT || operation == OP_NEXT)) |=> busy)
    else $error("query transfer did not raise busy");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_done_one_cycle: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // no result can follow a transfer in the very next cycle
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result one cycle after a transfer");

endmodule

bind animation_frame_at_time_top afat_checker u_afat_checker (.*);
